// File: hw/rtl/ppf_pkg.sv
// Shared constants, request codes and controller/datapath interface types.
package ppf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 18;
  localparam int OUT_W       = 22;
  localparam int CHAN_W      = 10;
  localparam int TAP_W       = 4;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int CHANNELS_W  = 11;
  localparam int TAPS_W      = 5;

  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_LOAD    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAPS     = 1'd1;

  localparam logic [CHANNELS_W-1:0] CHANNELS_RESET = 11'd1024;
  localparam logic [TAPS_W-1:0]     TAPS_RESET     = 5'd16;

  typedef struct packed {
    logic capture;
    logic coef_load;
    logic restart;
    logic issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic tap_last;
    logic pipe_busy;
    logic out_busy;
  } status_t;

endpackage

// File: hw/rtl/polyphase_fir_frontend.sv
// Top level of the polyphase filter bank FIR front end.
// Requests enter on req_valid/req_ready with an action code: a sample for the
// current channel, a coefficient pair load, or a restart of the stream counters.
// Loads, restarts and unknown actions finish in the accept cycle and give no result.
// A sample gives one result on res_valid/res_ready once enough frames are held:
// the filtered real and imaginary parts, the channel index and a frame_end flag.
// A producing sample passes the controller states in order: one multiply-accumulate
// issue per tap, with the tap count held to the range 1 to MAX_TAPS, through a single
// read port of each memory; a drain of the read and multiply stages; a history store
// and counter update, held while the previous result still waits; a return to idle.
// A sample that produces nothing goes from accept straight to the store and update.
// The result waits in an output register; the next request is taken while it
// waits, and a later result is held back only while the register is still full.
// Configuration registers are written on cfg_valid/cfg_ready, always ready, and
// should change only while no request is in flight.
// Synchronous reset restores the register defaults and clears the stream
// counters and the output valid; memory contents are kept and must be loaded.
module polyphase_fir_frontend #(
  parameter int MAX_CHANNELS = 1024,
  parameter int MAX_TAPS     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [1:0]                          action,
  input  logic signed [ppf_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [ppf_pkg::SAMPLE_W-1:0] sample_im,
  input  logic [ppf_pkg::TAP_W-1:0]           coef_tap,
  input  logic [ppf_pkg::CHAN_W-1:0]          coef_channel,
  input  logic signed [ppf_pkg::COEF_W-1:0]   coef_re,
  input  logic signed [ppf_pkg::COEF_W-1:0]   coef_im,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic signed [ppf_pkg::OUT_W-1:0]    out_re,
  output logic signed [ppf_pkg::OUT_W-1:0]    out_im,
  output logic [ppf_pkg::CHAN_W-1:0]          channel,
  output logic                                frame_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ppf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ppf_pkg::cmd_t    cmd;
  ppf_pkg::status_t status;

  assign cfg_ready = 1'b1;

  ppf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .action    (action),
    .status    (status),
    .cmd       (cmd)
  );

  ppf_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_TAPS     (MAX_TAPS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_re    (sample_re),
    .sample_im    (sample_im),
    .coef_tap     (coef_tap),
    .coef_channel (coef_channel),
    .coef_re      (coef_re),
    .coef_im      (coef_im),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .out_re       (out_re),
    .out_im       (out_im),
    .channel      (channel),
    .frame_end    (frame_end)
  );

endmodule

// File: hw/rtl/ppf_ctrl.sv
// Controller state machine that sequences requests through the filter datapath.
module ppf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [1:0]       action,
  input  ppf_pkg::status_t status,
  output ppf_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.coef_load = (action == ppf_pkg::ACT_LOAD);
          cmd.restart   = (action == ppf_pkg::ACT_RESTART);
          if (action == ppf_pkg::ACT_SAMPLE) begin
            cmd.capture = 1'b1;
            state_next  = status.produce ? ST_RUN : ST_DONE;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (status.tap_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.produce || !status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/ppf_datapath.sv
// Datapath: configuration, stream counters, history and coefficient memories, MAC and output.
module ppf_datapath #(
  parameter int MAX_CHANNELS = 1024,
  parameter int MAX_TAPS     = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ppf_pkg::cmd_t                         cmd,
  output ppf_pkg::status_t                      status,
  input  logic                                  cfg_valid,
  input  logic [ppf_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [ppf_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [ppf_pkg::SAMPLE_W-1:0]   sample_re,
  input  logic signed [ppf_pkg::SAMPLE_W-1:0]   sample_im,
  input  logic [ppf_pkg::TAP_W-1:0]             coef_tap,
  input  logic [ppf_pkg::CHAN_W-1:0]            coef_channel,
  input  logic signed [ppf_pkg::COEF_W-1:0]     coef_re,
  input  logic signed [ppf_pkg::COEF_W-1:0]     coef_im,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic signed [ppf_pkg::OUT_W-1:0]      out_re,
  output logic signed [ppf_pkg::OUT_W-1:0]      out_im,
  output logic [ppf_pkg::CHAN_W-1:0]            channel,
  output logic                                  frame_end
);

  localparam int CW         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int HS         = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int SW         = (HS > 1) ? $clog2(HS) : 1;
  localparam int FW         = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int HIST_DEPTH = HS * MAX_CHANNELS;
  localparam int COEF_DEPTH = MAX_TAPS * MAX_CHANNELS;
  localparam int HAW        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CAW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int SUM_W      = ppf_pkg::PROD_W + FW;
  localparam int ACC_W      = (SUM_W > ppf_pkg::FRAC_BITS + ppf_pkg::OUT_W) ?
                              SUM_W : ppf_pkg::FRAC_BITS + ppf_pkg::OUT_W;
  localparam int HIST_W     = 2 * ppf_pkg::SAMPLE_W;
  localparam int CPAIR_W    = 2 * ppf_pkg::COEF_W;

  logic [ppf_pkg::CHANNELS_W-1:0] cfg_channels;
  logic [ppf_pkg::TAPS_W-1:0]     cfg_taps;
  int                             nch;
  int                             ntp;

  logic [CW-1:0] pos;
  logic [FW-1:0] frames_filled;
  logic [SW-1:0] ring_slot;
  logic [FW-1:0] tap;
  logic          last;

  logic signed [ppf_pkg::SAMPLE_W-1:0] cur_re;
  logic signed [ppf_pkg::SAMPLE_W-1:0] cur_im;

  logic [HIST_W-1:0]  hist_mem [HIST_DEPTH];
  logic [CPAIR_W-1:0] coef_mem [COEF_DEPTH];
  logic [HIST_W-1:0]  hist_q;
  logic [CPAIR_W-1:0] coef_q;
  logic [HAW-1:0]     hist_raddr;
  logic [HAW-1:0]     hist_waddr;
  logic [CAW-1:0]     coef_raddr;
  logic [CAW-1:0]     coef_waddr;
  logic [31:0]        hist_raddr_full;
  logic [31:0]        hist_waddr_full;
  logic [31:0]        coef_raddr_full;
  logic [31:0]        coef_waddr_full;
  logic               coef_in_range;
  int                 hslot;

  logic                               rd_vld;
  logic                               rd_cur;
  logic                               mul_vld;
  logic signed [ppf_pkg::PROD_W-1:0]  prod_re;
  logic signed [ppf_pkg::PROD_W-1:0]  prod_im;
  logic signed [ppf_pkg::PROD_W-1:0]  prod_re_next;
  logic signed [ppf_pkg::PROD_W-1:0]  prod_im_next;
  logic signed [ppf_pkg::SAMPLE_W-1:0] mul_s_re;
  logic signed [ppf_pkg::SAMPLE_W-1:0] mul_s_im;
  logic signed [ppf_pkg::COEF_W-1:0]   mul_c_re;
  logic signed [ppf_pkg::COEF_W-1:0]   mul_c_im;
  logic signed [ACC_W-1:0]             acc_re;
  logic signed [ACC_W-1:0]             acc_im;

  // Out-of-range register values are clamped to the supported range.
  always_comb begin
    nch = int'(cfg_channels);
    if (nch == 0) begin
      nch = 1;
    end else if (nch > MAX_CHANNELS) begin
      nch = MAX_CHANNELS;
    end
    ntp = int'(cfg_taps);
    if (ntp == 0) begin
      ntp = 1;
    end else if (ntp > MAX_TAPS) begin
      ntp = MAX_TAPS;
    end
  end

  assign last = (int'(pos) + 1 >= nch);

  assign status.produce   = (int'(frames_filled) + 1 >= ntp);
  assign status.tap_last  = (int'(tap) == ntp - 1);
  assign status.pipe_busy = rd_vld || mul_vld;
  assign status.out_busy  = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_channels <= ppf_pkg::CHANNELS_RESET;
      cfg_taps     <= ppf_pkg::TAPS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ppf_pkg::REG_CHANNELS: begin
          cfg_channels <= cfg_data;
        end
        ppf_pkg::REG_TAPS: begin
          cfg_taps <= cfg_data[ppf_pkg::TAPS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Tap k = 0 is the newest frame, taken from the captured sample; tap k
  // reads the history slot k frames back and the coefficient of tap ntp-1-k.
  always_comb begin
    hslot = int'(ring_slot) - int'(tap);
    if (hslot < 0) begin
      hslot = hslot + HS;
    end
    hist_raddr_full = 32'(hslot * MAX_CHANNELS + int'(pos));
    hist_waddr_full = 32'(int'(ring_slot) * MAX_CHANNELS + int'(pos));
    coef_raddr_full = 32'((ntp - 1 - int'(tap)) * MAX_CHANNELS + int'(pos));
    coef_waddr_full = 32'(int'(coef_tap) * MAX_CHANNELS + int'(coef_channel));
  end

  assign hist_raddr    = hist_raddr_full[HAW-1:0];
  assign hist_waddr    = hist_waddr_full[HAW-1:0];
  assign coef_raddr    = coef_raddr_full[CAW-1:0];
  assign coef_waddr    = coef_waddr_full[CAW-1:0];
  assign coef_in_range = (int'(coef_tap) < MAX_TAPS) && (int'(coef_channel) < MAX_CHANNELS);

  always_ff @(posedge clk) begin
    if (cmd.coef_load && coef_in_range) begin
      coef_mem[coef_waddr] <= {coef_im, coef_re};
    end
    if (cmd.issue) begin
      coef_q <= coef_mem[coef_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hist_mem[hist_waddr] <= {cur_im, cur_re};
    end
    if (cmd.issue) begin
      hist_q <= hist_mem[hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_re <= sample_re;
      cur_im <= sample_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (cmd.capture) begin
      tap <= '0;
    end else if (cmd.issue) begin
      tap <= tap + 1'b1;
    end
  end

  always_comb begin
    mul_c_re     = coef_q[ppf_pkg::COEF_W-1:0];
    mul_c_im     = coef_q[CPAIR_W-1:ppf_pkg::COEF_W];
    mul_s_re     = rd_cur ? cur_re : hist_q[ppf_pkg::SAMPLE_W-1:0];
    mul_s_im     = rd_cur ? cur_im : hist_q[HIST_W-1:ppf_pkg::SAMPLE_W];
    prod_re_next = mul_c_re * mul_s_re;
    prod_im_next = mul_c_im * mul_s_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      rd_vld  <= cmd.issue;
      mul_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_cur <= (tap == '0);
    end
    if (rd_vld) begin
      prod_re <= prod_re_next;
      prod_im <= prod_im_next;
    end
    if (cmd.capture) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (mul_vld) begin
      acc_re <= acc_re + ACC_W'(prod_re);
      acc_im <= acc_im + ACC_W'(prod_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      pos           <= '0;
      frames_filled <= '0;
      ring_slot     <= '0;
    end else if (cmd.commit) begin
      if (last) begin
        pos <= '0;
        if (int'(ring_slot) == HS - 1) begin
          ring_slot <= '0;
        end else begin
          ring_slot <= ring_slot + 1'b1;
        end
        if (int'(frames_filled) < MAX_TAPS - 1) begin
          frames_filled <= frames_filled + 1'b1;
        end
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit && status.produce) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && status.produce) begin
      out_re    <= acc_re[ppf_pkg::FRAC_BITS+ppf_pkg::OUT_W-1:ppf_pkg::FRAC_BITS];
      out_im    <= acc_im[ppf_pkg::FRAC_BITS+ppf_pkg::OUT_W-1:ppf_pkg::FRAC_BITS];
      channel   <= ppf_pkg::CHAN_W'(pos);
      frame_end <= last;
    end
  end

  a_commit_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !rd_vld && !mul_vld)
    else $error("Commit while multiply-accumulate pipeline still holds terms.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && status.produce) |-> !(res_valid && !res_ready))
    else $error("Result register overwritten before it was taken.");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && status.produce) |=> res_valid)
    else $error("Finished result did not appear on the output.");

endmodule
